>>> design/blr_pkg.sv
// ---------------------------------------------------------------------------
// blr_pkg
// Shared types and constants for the line rasteriser.
// ---------------------------------------------------------------------------
package blr_pkg;

   localparam int CoordBits   = 11;
   localparam int SpanBits    = CoordBits + 1;
   localparam int OffsetBits  = 22;
   localparam int PitchBits   = 12;
   localparam int ColorBits   = 16;
   localparam int MaxPixels   = 64;
   localparam int QueueDepth  = 2;
   localparam int CsrAddrBits = 3;
   localparam int CsrDataBits = 32;

   localparam logic [PitchBits-1:0] PitchReset = PitchBits'(640);
   localparam logic [ColorBits-1:0] ColorReset = ColorBits'(65535);

   typedef enum logic {
      OP_MOVE = 1'b0,
      OP_LINE = 1'b1
   } op_type;

   typedef enum logic {
      REG_PITCH = 1'b0,
      REG_COLOR = 1'b1
   } csr_reg_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_WALK
   } back_state_type;

   typedef struct packed {
      logic [CoordBits-1:0] start_x;
      logic [CoordBits-1:0] start_y;
      logic                 x_neg;
      logic                 y_neg;
      logic                 x_major;
      logic [SpanBits-1:0]  major;
      logic [SpanBits-1:0]  minor;
      logic                 trunc;
   } line_desc_type;

endpackage

>>> design/bresenham_line_rasterizer.sv
// ---------------------------------------------------------------------------
// bresenham_line_rasterizer
// Line rasteriser with a current point: move and line commands in, one
// framebuffer write (offset, colour) out per pixel.
//
//   Channel  Dir  Content
//   req_*    in   command transaction: move or line to (x, y)
//   rsp_*    out  pixel transaction: offset, colour, last, truncated
//   csr_*    in   APB registers: pitch at 0x0, colour at 0x4
//
// A move only updates the current point in the front end. A line loads the
// walker, which emits min(max(|dx|,|dy|)+1, MAX_PIXELS) pixels from its
// accumulator step, one pixel per cycle unless the output stalls. A two-entry
// queue lets the front end take commands while the walker runs. Reset is
// synchronous: current point 0, pitch 640, colour 0xFFFF. Output stalls hold
// the walker; once the queue is full the front end stops taking commands too.
// ---------------------------------------------------------------------------
module bresenham_line_rasterizer
   import blr_pkg::*;
#(
   parameter int MAX_PIXELS = MaxPixels
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [23:0]            req_tdata,   // target_x, target_y, pad
   input  logic                   req_tuser,   // op
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [39:0]            rsp_tdata,   // pixel_offset, pixel_value, pad
   output logic                   rsp_tlast,   // last_pixel
   output logic                   rsp_tuser,   // truncated
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CsrAddrBits-1:0] csr_paddr,
   input  logic [CsrDataBits-1:0] csr_pwdata,
   output logic [CsrDataBits-1:0] csr_prdata,
   output logic                   csr_pready
);

   logic [PitchBits-1:0] pitch_ff, pitch_in;
   logic [ColorBits-1:0] color_ff, color_in;
   logic                 csr_write;
   csr_reg_type          csr_sel;

   logic                 q_full, q_push, q_pop, q_valid;
   line_desc_type        push_desc, pop_desc;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = csr_reg_type'(csr_paddr[2]);

   always_comb begin
      pitch_in = pitch_ff;
      color_in = color_ff;
      if (csr_write) begin
         case (csr_sel)
            REG_PITCH: pitch_in = csr_pwdata[PitchBits-1:0];
            REG_COLOR: color_in = csr_pwdata[ColorBits-1:0];
            default: begin
               pitch_in = pitch_ff;
               color_in = color_ff;
            end
         endcase
      end
      case (csr_sel)
         REG_PITCH: csr_prdata = CsrDataBits'(pitch_ff);
         REG_COLOR: csr_prdata = CsrDataBits'(color_ff);
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= PitchReset;
         color_ff <= ColorReset;
      end else begin
         pitch_ff <= pitch_in;
         color_ff <= color_in;
      end
   end

   blr_front #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_desc     (push_desc)
   );

   blr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_desc  (pop_desc)
   );

   blr_back #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pitch      (pitch_ff),
      .color      (color_ff),
      .q_valid    (q_valid),
      .q_desc     (pop_desc),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> design/blr_front.sv
// ---------------------------------------------------------------------------
// blr_front
// Takes commands, keeps the current point and turns line commands into
// span descriptors for the walker.
// ---------------------------------------------------------------------------
module blr_front
   import blr_pkg::*;
#(
   parameter int MAX_PIXELS = MaxPixels
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,
   input  logic                 req_tuser,
   input  logic                 q_full,
   output logic                 q_push,
   output line_desc_type        q_desc
);

   logic [CoordBits-1:0] cur_x_ff, cur_x_in;
   logic [CoordBits-1:0] cur_y_ff, cur_y_in;
   logic [CoordBits-1:0] tx, ty, dx, dy;
   logic [SpanBits-1:0]  sx, sy;
   logic                 accept;
   logic                 x_neg, y_neg, x_major;

   assign tx         = req_tdata[CoordBits-1:0];
   assign ty         = req_tdata[2*CoordBits-1:CoordBits];
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      x_neg   = tx < cur_x_ff;
      y_neg   = ty < cur_y_ff;
      dx      = x_neg ? cur_x_ff - tx : tx - cur_x_ff;
      dy      = y_neg ? cur_y_ff - ty : ty - cur_y_ff;
      sx      = {1'b0, dx} + SpanBits'(1);
      sy      = {1'b0, dy} + SpanBits'(1);
      x_major = !(sx < sy);

      q_desc.start_x = cur_x_ff;
      q_desc.start_y = cur_y_ff;
      q_desc.x_neg   = x_neg;
      q_desc.y_neg   = y_neg;
      q_desc.x_major = x_major;
      q_desc.major   = x_major ? sx : sy;
      q_desc.minor   = x_major ? sy : sx;
      q_desc.trunc   = q_desc.major > SpanBits'(MAX_PIXELS);

      q_push   = accept && (op_type'(req_tuser) == OP_LINE);
      cur_x_in = accept ? tx : cur_x_ff;
      cur_y_in = accept ? ty : cur_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
      end else begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
      end
   end

endmodule

>>> design/blr_queue.sv
// ---------------------------------------------------------------------------
// blr_queue
// Short descriptor queue between the front end and the walker.
// ---------------------------------------------------------------------------
module blr_queue
   import blr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  line_desc_type push_desc,
   output logic          full,
   input  logic          pop,
   output logic          valid,
   output line_desc_type pop_desc
);

   localparam int PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntBits = $clog2(QueueDepth + 1);

   line_desc_type        entry_ff [QueueDepth];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = count_ff == CntBits'(QueueDepth);
   assign valid    = count_ff != '0;
   assign pop_desc = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PtrBits'(1);
      end
      count_in = count_ff + CntBits'(do_push) - CntBits'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

>>> design/blr_back.sv
// ---------------------------------------------------------------------------
// blr_back
// Pixel walker: steps along the major axis one pixel per cycle unless the
// output stalls; the framebuffer offset is stepped after one start multiply.
// ---------------------------------------------------------------------------
module blr_back
   import blr_pkg::*;
#(
   parameter int MAX_PIXELS = MaxPixels
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [PitchBits-1:0] pitch,
   input  logic [ColorBits-1:0] color,
   input  logic                 q_valid,
   input  line_desc_type        q_desc,
   output logic                 q_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,
   output logic                 rsp_tlast,
   output logic                 rsp_tuser
);

   localparam int RemBits = $clog2(MAX_PIXELS);
   localparam int SumBits = SpanBits + 1;
   localparam int ProdBits = CoordBits + PitchBits;

   back_state_type          state_ff, state_in;
   logic [OffsetBits-1:0]   offset_ff, offset_in;
   logic [SpanBits-1:0]     sum_ff, sum_in;
   logic [RemBits-1:0]      rem_ff, rem_in;
   logic [SpanBits-1:0]     major_ff, minor_ff;
   logic                    x_neg_ff, y_neg_ff, x_major_ff, trunc_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [OffsetBits-1:0]   out_offset_ff;
   logic [ColorBits-1:0]    out_color_ff;
   logic                    out_last_ff, out_trunc_ff;

   logic                    out_free, load, emit, adv, last;
   logic [SumBits-1:0]      acc;
   logic [ProdBits-1:0]     prod;
   logic [OffsetBits-1:0]   x_step, y_step, x_inc, y_inc, pitch_ext;

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: if (q_valid) state_in = BACK_WALK;
         BACK_WALK: if (out_free && rem_ff == '0) state_in = BACK_IDLE;
         default:   state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      load = 1'b0;
      emit = 1'b0;
      case (state_ff)
         BACK_IDLE: load = q_valid;
         BACK_WALK: emit = out_free;
         default: begin
            load = 1'b0;
            emit = 1'b0;
         end
      endcase
   end

   assign q_pop = load;

   always_comb begin
      prod      = ProdBits'(q_desc.start_y) * ProdBits'(pitch);
      acc       = {1'b0, sum_ff} + {1'b0, minor_ff};
      adv       = acc >= {1'b0, major_ff};
      last      = rem_ff == '0;
      pitch_ext = OffsetBits'(pitch);
      x_step    = x_neg_ff ? '1 : OffsetBits'(1);
      y_step    = y_neg_ff ? (~pitch_ext + OffsetBits'(1)) : pitch_ext;
      x_inc     = (x_major_ff || adv) ? x_step : '0;
      y_inc     = (!x_major_ff || adv) ? y_step : '0;

      offset_in    = offset_ff;
      sum_in       = sum_ff;
      rem_in       = rem_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (load) begin
         offset_in = prod[OffsetBits-1:0] + OffsetBits'(q_desc.start_x);
         sum_in    = '0;
         rem_in    = q_desc.trunc ? RemBits'(MAX_PIXELS - 1)
                                  : RemBits'(q_desc.major - SpanBits'(1));
      end else if (emit) begin
         offset_in    = offset_ff + x_inc + y_inc;
         sum_in       = adv ? SpanBits'(acc - {1'b0, major_ff}) : SpanBits'(acc);
         rem_in       = rem_ff - RemBits'(1);
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      sum_ff    <= sum_in;
      rem_ff    <= rem_in;
      if (load) begin
         major_ff   <= q_desc.major;
         minor_ff   <= q_desc.minor;
         x_neg_ff   <= q_desc.x_neg;
         y_neg_ff   <= q_desc.y_neg;
         x_major_ff <= q_desc.x_major;
         trunc_ff   <= q_desc.trunc;
      end
      if (emit) begin
         out_offset_ff <= offset_ff;
         out_color_ff  <= color;
         out_last_ff   <= last;
         out_trunc_ff  <= last && trunc_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_color_ff, out_offset_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_trunc_ff;

endmodule
